### hdl/ushf_pkg.sv
// shared types, constants and register codes for the ungapped hit score filter
package ushf_pkg;

    localparam int ALPHABET_SIZE_DEF = 32;
    localparam int TABLE_SIDE_MAX    = 32;
    localparam int LETTER_W          = 5;
    localparam int SCORE_W           = 8;
    localparam int INDEX_W           = 16;
    localparam int LEN_W             = 7;
    localparam int COUNT_W           = 8;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_SPAN     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLANK_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCORE_THRESH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_SCORE = 2'd3;

    localparam logic [LEN_W-1:0]   SEED_SPAN_RST     = 7'd4;
    localparam logic [LEN_W-1:0]   FLANK_LENGTH_RST  = 7'd8;
    localparam logic [SCORE_W-1:0] SCORE_THRESH_RST  = 8'd20;
    localparam logic [SCORE_W-1:0] DEFAULT_SCORE_RST = 8'hfc;

    localparam logic [LEN_W-1:0]   SPAN_MIN   = 7'd1;
    localparam logic [LEN_W-1:0]   LEN_MAX    = 7'd64;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 8'hff;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SCORE = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]   seed_span;
        logic [LEN_W-1:0]   flank_length;
        logic [SCORE_W-1:0] score_threshold;
        logic [SCORE_W-1:0] default_score;
    } t_cfg;

    typedef struct packed {
        logic               in_alpha;
        logic [INDEX_W-1:0] subject_index;
        logic [INDEX_W-1:0] query_index;
    } t_stage;

    typedef struct packed {
        logic               passed;
        logic [SCORE_W-1:0] best_value;
        logic [INDEX_W-1:0] hit_query;
        logic [INDEX_W-1:0] hit_subject;
    } t_hit;

endpackage

### hdl/ungapped_hit_score_filter_core.sv
// top level of the ungapped hit score filter
//
//   channel   direction  handshake                  payload
//   s_axis    in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (mode)
//   m_axis    out        o_m_tvalid / i_m_tready    o_m_tdata
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle unless stalled; a table read issued at accept is registered
// for the score stage, and a finished pair's result goes to the output register.
// the score loop is a saturating add, a bias compare and subtract, a best compare.
// reset clears pair state and presets config; table stays undefined until loaded.
// input stalls only when a pair ends while the output register is still full.
module ungapped_hit_score_filter_core #(
    parameter int ALPHABET_SIZE = ushf_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // subject_letter[4:0], query_letter[9:5], table_value[17:10],
    // subject_index[33:18], query_index[49:34], zero fill [55:50]
    input  logic [55:0]                        i_s_tdata,
    // mode[0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // hit_subject[15:0], hit_query[31:16], best_value[39:32], passed[40],
    // zero fill [47:41]
    output logic [47:0]                        o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ushf_pkg::CFG_ADDR_W-1:0]    i_cfg_index,
    input  logic [ushf_pkg::SCORE_W-1:0]       i_cfg_data
);

    localparam int SIDE = (ALPHABET_SIZE < ushf_pkg::TABLE_SIDE_MAX) ?
                          ALPHABET_SIZE : ushf_pkg::TABLE_SIDE_MAX;
    localparam int LTW  = $clog2(SIDE);
    localparam int AW   = 2 * LTW;
    localparam logic [ushf_pkg::LETTER_W:0] SIDE_V = (ushf_pkg::LETTER_W+1)'(SIDE);

    ushf_pkg::t_cfg   r_cfg;
    ushf_pkg::t_stage item;
    ushf_pkg::t_hit   hit;

    logic [ushf_pkg::LETTER_W-1:0] subj_letter;
    logic [ushf_pkg::LETTER_W-1:0] qry_letter;
    logic [ushf_pkg::SCORE_W-1:0]  table_value;
    logic                          in_alpha;
    logic                          accept;
    logic                          rdy;
    logic [AW-1:0]                 addr;
    logic [ushf_pkg::SCORE_W-1:0]  rdata;

    assign subj_letter = i_s_tdata[4:0];
    assign qry_letter  = i_s_tdata[9:5];
    assign table_value = i_s_tdata[17:10];

    assign in_alpha = ({1'b0, subj_letter} < SIDE_V) && ({1'b0, qry_letter} < SIDE_V);
    assign addr     = {subj_letter[LTW-1:0], qry_letter[LTW-1:0]};
    assign accept   = i_s_tvalid && rdy;

    assign item.in_alpha      = in_alpha;
    assign item.subject_index = i_s_tdata[33:18];
    assign item.query_index   = i_s_tdata[49:34];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_span       <= ushf_pkg::SEED_SPAN_RST;
            r_cfg.flank_length    <= ushf_pkg::FLANK_LENGTH_RST;
            r_cfg.score_threshold <= ushf_pkg::SCORE_THRESH_RST;
            r_cfg.default_score   <= ushf_pkg::DEFAULT_SCORE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ushf_pkg::CFG_SEED_SPAN:     r_cfg.seed_span <= i_cfg_data[ushf_pkg::LEN_W-1:0];
                ushf_pkg::CFG_FLANK_LENGTH:  r_cfg.flank_length <= i_cfg_data[ushf_pkg::LEN_W-1:0];
                ushf_pkg::CFG_SCORE_THRESH:  r_cfg.score_threshold <= i_cfg_data;
                ushf_pkg::CFG_DEFAULT_SCORE: r_cfg.default_score <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ushf_table #(
        .AW (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_wr_en (accept && (i_s_tuser == ushf_pkg::MODE_LOAD) && in_alpha),
        .i_rd_en (accept && (i_s_tuser == ushf_pkg::MODE_SCORE)),
        .i_addr  (addr),
        .i_wdata (table_value),
        .o_rdata (rdata)
    );

    ushf_score u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (accept && (i_s_tuser == ushf_pkg::MODE_SCORE)),
        .i_item   (item),
        .o_rdy    (rdy),
        .i_rdata  (rdata),
        .o_vld    (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_hit    (hit)
    );

    assign o_s_tready = rdy;
    assign o_m_tdata  = {7'd0, hit.passed, hit.best_value, hit.hit_query, hit.hit_subject};

endmodule

### hdl/ushf_table.sv
// substitution table memory, one write or one registered read per cycle
module ushf_table #(
    parameter int AW = 10
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_addr,
    input  logic [ushf_pkg::SCORE_W-1:0]  i_wdata,
    output logic [ushf_pkg::SCORE_W-1:0]  o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [ushf_pkg::SCORE_W-1:0] r_mem [DEPTH];
    logic [ushf_pkg::SCORE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data holds until the next read so a stalled stage keeps its entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ushf_score.sv
// running score update, pair bookkeeping and output register
module ushf_score (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ushf_pkg::t_cfg                i_cfg,
    input  logic                          i_vld,
    input  ushf_pkg::t_stage              i_item,
    output logic                          o_rdy,
    input  logic [ushf_pkg::SCORE_W-1:0]  i_rdata,
    output logic                          o_vld,
    input  logic                          i_tready,
    output ushf_pkg::t_hit                o_hit
);

    localparam int SW = ushf_pkg::SCORE_W;
    localparam int LW = ushf_pkg::LEN_W;
    localparam int CW = ushf_pkg::COUNT_W;

    logic             r_vld;
    ushf_pkg::t_stage r_item;
    logic [SW-1:0]    r_run;
    logic [SW-1:0]    r_best;
    logic [CW-1:0]    r_count;
    logic             r_o_vld;
    ushf_pkg::t_hit   r_hit;

    logic [SW-1:0]    n_run;
    logic [SW-1:0]    n_best;
    logic [CW-1:0]    n_count;

    logic [SW-1:0]    value;
    logic [SW-1:0]    entry;
    logic [SW-1:0]    rbias;
    logic [SW:0]      sum;
    logic [SW-1:0]    sat;
    logic [SW-1:0]    new_score;
    logic [SW-1:0]    best_upd;
    logic [LW-1:0]    span;
    logic [LW-1:0]    flank;
    logic [CW-1:0]    half;
    logic [CW-1:0]    total;
    logic [CW:0]      count;
    logic             emit;
    logic             out_free;
    logic             go;

    always_comb begin
        value = r_item.in_alpha ? i_rdata : i_cfg.default_score;
        entry = value - i_cfg.default_score;
        rbias = SW'(0) - i_cfg.default_score;
        sum   = {1'b0, r_run} + {1'b0, entry};
        sat   = sum[SW] ? ushf_pkg::SCORE_MAX : sum[SW-1:0];
        new_score = (sat > rbias) ? (sat - rbias) : '0;
        best_upd  = (new_score > r_best) ? new_score : r_best;

        span  = (i_cfg.seed_span < ushf_pkg::SPAN_MIN) ? ushf_pkg::SPAN_MIN :
                ((i_cfg.seed_span > ushf_pkg::LEN_MAX) ? ushf_pkg::LEN_MAX
                                                       : i_cfg.seed_span);
        flank = (i_cfg.flank_length > ushf_pkg::LEN_MAX) ? ushf_pkg::LEN_MAX
                                                         : i_cfg.flank_length;
        half  = CW'(span) + CW'(flank);
        total = half + CW'(flank);
        count = {1'b0, r_count} + (CW+1)'(1);
        emit  = r_vld && (count >= {1'b0, total});
    end

    assign out_free = !r_o_vld || i_tready;
    assign go       = r_vld && (!emit || out_free);
    assign o_rdy    = !r_vld || go;

    always_comb begin
        n_run   = r_run;
        n_best  = r_best;
        n_count = r_count;
        if (go) begin
            if (emit) begin
                n_run   = '0;
                n_best  = '0;
                n_count = '0;
            end else begin
                // midpoint: restart the right flank from the best so far
                n_run   = (count == {1'b0, half}) ? best_upd : new_score;
                n_best  = best_upd;
                n_count = count[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_run   <= '0;
            r_best  <= '0;
            r_count <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_best  <= n_best;
            r_count <= n_count;
            if (i_vld) begin
                r_vld <= 1'b1;
            end else if (go) begin
                r_vld <= 1'b0;
            end
            if (go && emit) begin
                r_o_vld <= 1'b1;
            end else if (i_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_item <= i_item;
        end
        if (go && emit) begin
            r_hit.hit_subject <= r_item.subject_index;
            r_hit.hit_query   <= r_item.query_index;
            r_hit.best_value  <= best_upd;
            r_hit.passed      <= (best_upd >= i_cfg.score_threshold);
        end
    end

    assign o_vld = r_o_vld;
    assign o_hit = r_hit;

endmodule
